// File: sv/wac_pkg.sv
// types, constants and character classes for the accession checker
// no dependencies
`default_nettype none

package wac_pkg;

  typedef enum logic [1:0] {
    PH_LETTERS,
    PH_VERSION,
    PH_TYPE,
    PH_ROW
  } phase_t;

  localparam logic [1:0] KIND_CONTIG   = 2'd0;
  localparam logic [1:0] KIND_SCAFFOLD = 2'd1;
  localparam logic [1:0] KIND_PROTEIN  = 2'd2;

  localparam logic [2:0] KIND_MASK_RESET = 3'd3;

  localparam logic [7:0] CH_S_LO  = 8'h73;
  localparam logic [7:0] CH_S_UP  = 8'h53;
  localparam logic [7:0] CH_P_LO  = 8'h70;
  localparam logic [7:0] CH_P_UP  = 8'h50;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_Z_UP  = 8'h5a;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_Z_LO  = 8'h7a;

  localparam logic [4:0] POS_MAX      = 5'd31;
  localparam logic [4:0] LEN_MIN      = 5'd12;
  localparam logic [4:0] LEN_MAX      = 5'd18;
  localparam logic [2:0] LETTERS_FOUR = 3'd4;
  localparam logic [2:0] LETTERS_FIVE = 3'd5;
  localparam logic [2:0] LETTERS_SIX  = 3'd6;
  localparam logic [3:0] ROW_CNT_MAX  = 4'd15;
  localparam logic [3:0] ROW_MIN_FOUR = 4'd6;
  localparam logic [3:0] ROW_MAX_FOUR = 4'd7;
  localparam logic [3:0] ROW_MIN_SIX  = 4'd7;
  localparam logic [3:0] ROW_MAX_SIX  = 4'd9;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CH_A_UP) && (c <= CH_Z_UP)) || ((c >= CH_A_LO) && (c <= CH_Z_LO));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

`default_nettype wire

// File: sv/wgs_accession_checker.sv
// accession format checker: one character per beat, one verdict per string
// depends on wac_pkg
`default_nettype none

// channel  | handshake           | payload
// ---------+---------------------+----------------------------------------
// in       | in_valid / in_ready | char_code[7:0], last_char
// out      | out_valid/out_ready | accepted, seq_kind[1:0], six_letter_form
// cfg      | cfg_wr_en           | cfg_wr_data[2:0] (allowed kinds mask)
//
// one character per cycle while in_ready is high; the parse state updates on the accepting edge
// the verdict is registered into the output register on the edge that accepts the last character
// in_ready is low only while a verdict waits with out_ready low
// rst (synchronous) clears parse state, the output register and sets the mask to 3

module wgs_accession_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] char_code,
  input  wire logic       last_char,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            accepted,
  output logic [1:0]      seq_kind,
  output logic            six_letter_form,
  input  wire logic       cfg_wr_en,
  input  wire logic [2:0] cfg_wr_data
);

  logic [2:0]      allowed_kinds;
  logic [4:0]      char_position;
  wac_pkg::phase_t parse_phase;
  logic [2:0]      letter_run;
  logic [1:0]      version_digit_count;
  logic [3:0]      row_digit_count;
  logic            row_nonzero;
  logic [1:0]      kind_seen;
  logic            failed;

  logic [4:0]      char_position_next;
  wac_pkg::phase_t parse_phase_next;
  logic [2:0]      letter_run_next;
  logic [1:0]      version_digit_count_next;
  logic [3:0]      row_digit_count_next;
  logic            row_nonzero_next;
  logic [1:0]      kind_seen_next;
  logic            failed_next;

  logic            in_fire;
  logic            take_row;
  logic            take_version;
  logic            six;
  logic [3:0]      row_min;
  logic [3:0]      row_max;
  logic            verdict_ok;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // next parse state for the current beat
  always_comb begin
    char_position_next       = (char_position != wac_pkg::POS_MAX) ?
                               char_position + 5'd1 : char_position;
    parse_phase_next         = parse_phase;
    letter_run_next          = letter_run;
    version_digit_count_next = version_digit_count;
    row_digit_count_next     = row_digit_count;
    row_nonzero_next         = row_nonzero;
    kind_seen_next           = kind_seen;
    failed_next              = failed;
    take_row                 = 1'b0;
    take_version             = 1'b0;

    if (!failed) begin
      unique case (parse_phase)
        wac_pkg::PH_LETTERS: begin
          if (wac_pkg::is_letter(char_code)) begin
            letter_run_next = letter_run + 3'd1;
            if (letter_run == wac_pkg::LETTERS_FIVE) begin
              parse_phase_next = wac_pkg::PH_VERSION;
            end
          end else if (letter_run == wac_pkg::LETTERS_FOUR) begin
            parse_phase_next = wac_pkg::PH_VERSION;
            take_version     = 1'b1;
          end else begin
            failed_next = 1'b1;
          end
        end
        wac_pkg::PH_VERSION: begin
          take_version = 1'b1;
        end
        wac_pkg::PH_TYPE: begin
          parse_phase_next = wac_pkg::PH_ROW;
          if (char_code == wac_pkg::CH_S_LO || char_code == wac_pkg::CH_S_UP) begin
            kind_seen_next = wac_pkg::KIND_SCAFFOLD;
          end else if (char_code == wac_pkg::CH_P_LO || char_code == wac_pkg::CH_P_UP) begin
            kind_seen_next = wac_pkg::KIND_PROTEIN;
          end else begin
            kind_seen_next = wac_pkg::KIND_CONTIG;
            take_row       = 1'b1;
          end
        end
        wac_pkg::PH_ROW: begin
          take_row = 1'b1;
        end
        default: begin
          failed_next = 1'b1;
        end
      endcase
    end

    if (take_version) begin
      if (wac_pkg::is_digit(char_code)) begin
        version_digit_count_next = version_digit_count + 2'd1;
        if (version_digit_count != 2'd0) begin
          parse_phase_next = wac_pkg::PH_TYPE;
        end
      end else begin
        failed_next = 1'b1;
      end
    end

    if (take_row) begin
      if (wac_pkg::is_digit(char_code)) begin
        if (row_digit_count != wac_pkg::ROW_CNT_MAX) begin
          row_digit_count_next = row_digit_count + 4'd1;
        end
        if (char_code != wac_pkg::CH_ZERO) begin
          row_nonzero_next = 1'b1;
        end
      end else begin
        failed_next = 1'b1;
      end
    end
  end

  // verdict from the updated state
  always_comb begin
    six        = (letter_run_next == wac_pkg::LETTERS_SIX);
    row_min    = six ? wac_pkg::ROW_MIN_SIX : wac_pkg::ROW_MIN_FOUR;
    row_max    = six ? wac_pkg::ROW_MAX_SIX : wac_pkg::ROW_MAX_FOUR;
    verdict_ok = !failed_next
                 && (parse_phase_next == wac_pkg::PH_ROW)
                 && (char_position_next >= wac_pkg::LEN_MIN)
                 && (char_position_next <= wac_pkg::LEN_MAX)
                 && (kind_seen_next != 2'd3)
                 && allowed_kinds[kind_seen_next]
                 && (row_digit_count_next >= row_min)
                 && (row_digit_count_next <= row_max)
                 && row_nonzero_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      allowed_kinds       <= wac_pkg::KIND_MASK_RESET;
      char_position       <= '0;
      parse_phase         <= wac_pkg::PH_LETTERS;
      letter_run          <= '0;
      version_digit_count <= '0;
      row_digit_count     <= '0;
      row_nonzero         <= 1'b0;
      kind_seen           <= wac_pkg::KIND_CONTIG;
      failed              <= 1'b0;
      out_valid           <= 1'b0;
      accepted            <= 1'b0;
      seq_kind            <= wac_pkg::KIND_CONTIG;
      six_letter_form     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        allowed_kinds <= cfg_wr_data;
      end

      if (in_fire) begin
        if (last_char) begin
          // end of string: back to the start state
          char_position       <= '0;
          parse_phase         <= wac_pkg::PH_LETTERS;
          letter_run          <= '0;
          version_digit_count <= '0;
          row_digit_count     <= '0;
          row_nonzero         <= 1'b0;
          kind_seen           <= wac_pkg::KIND_CONTIG;
          failed              <= 1'b0;
        end else begin
          char_position       <= char_position_next;
          parse_phase         <= parse_phase_next;
          letter_run          <= letter_run_next;
          version_digit_count <= version_digit_count_next;
          row_digit_count     <= row_digit_count_next;
          row_nonzero         <= row_nonzero_next;
          kind_seen           <= kind_seen_next;
          failed              <= failed_next;
        end
      end

      if (in_fire && last_char) begin
        out_valid       <= 1'b1;
        accepted        <= verdict_ok;
        seq_kind        <= verdict_ok ? kind_seen_next : wac_pkg::KIND_CONTIG;
        six_letter_form <= verdict_ok && six;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_reject_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> seq_kind == wac_pkg::KIND_CONTIG && !six_letter_form)
    else $error("rejected verdict carries kind or form");

  a_verdict_follows_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_char |=> out_valid)
    else $error("no verdict after last character");

  a_kind_in_range: assert property (@(posedge clk) disable iff (rst)
    kind_seen != 2'd3 && (!out_valid || seq_kind != 2'd3))
    else $error("kind code out of range");

  a_start_state_clean: assert property (@(posedge clk) disable iff (rst)
    char_position == 5'd0 |-> parse_phase == wac_pkg::PH_LETTERS && !failed
                              && letter_run == 3'd0)
    else $error("parse state not clear at string start");

endmodule

`default_nettype wire

// File: tb/sv/wgs_accession_checker_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for wgs_accession_checker: strings go in one character per
// beat, a scoreboard class predicts each verdict and checks the output channel
// depends on wac_pkg and wgs_accession_checker

module wgs_accession_checker_tb;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int SEG_ITEMS   = 200;
  localparam logic [2:0] MASK_PLAN [0:7] = '{3'd7, 3'd0, 3'd1, 3'd2, 3'd4, 3'd5, 3'd6, 3'd3};

  class accession_scoreboard;
    typedef struct packed {
      logic       acc;
      logic [1:0] kind;
      logic       six;
    } verdict_t;

    verdict_t        verdict_q[$];
    int              errors;
    logic [2:0]      kinds_mask;
    logic [4:0]      pos;
    wac_pkg::phase_t phase;
    logic [2:0]      letters;
    logic [1:0]      ver_cnt;
    logic [3:0]      row_cnt;
    logic            row_nz;
    logic [1:0]      kind;
    logic            bad;

    function new();
      errors = 0;
      kinds_mask = wac_pkg::KIND_MASK_RESET;
      clear();
    endfunction

    function void clear();
      pos = '0;
      phase = wac_pkg::PH_LETTERS;
      letters = '0;
      ver_cnt = '0;
      row_cnt = '0;
      row_nz = 1'b0;
      kind = wac_pkg::KIND_CONTIG;
      bad = 1'b0;
    endfunction

    function bit is_alpha(input logic [7:0] c);
      return (c >= wac_pkg::CH_A_UP && c <= wac_pkg::CH_Z_UP)
          || (c >= wac_pkg::CH_A_LO && c <= wac_pkg::CH_Z_LO);
    endfunction

    function bit is_num(input logic [7:0] c);
      return c >= wac_pkg::CH_ZERO && c <= wac_pkg::CH_NINE;
    endfunction

    function void take_version(input logic [7:0] c);
      if (!is_num(c)) begin
        bad = 1'b1;
      end else begin
        ver_cnt++;
        if (ver_cnt == 2'd2) phase = wac_pkg::PH_TYPE;
      end
    endfunction

    function void take_row(input logic [7:0] c);
      if (!is_num(c)) begin
        bad = 1'b1;
      end else begin
        if (row_cnt != wac_pkg::ROW_CNT_MAX) row_cnt++;
        if (c != wac_pkg::CH_ZERO) row_nz = 1'b1;
      end
    endfunction

    function void note_char(input logic [7:0] c, input logic last);
      verdict_t   v;
      logic       six;
      logic       ok;
      logic [3:0] rmin;
      logic [3:0] rmax;
      if (pos != wac_pkg::POS_MAX) pos++;
      if (!bad) begin
        case (phase)
          wac_pkg::PH_LETTERS: begin
            if (is_alpha(c)) begin
              letters++;
              if (letters >= wac_pkg::LETTERS_SIX) phase = wac_pkg::PH_VERSION;
            end else if (letters == wac_pkg::LETTERS_FOUR) begin
              phase = wac_pkg::PH_VERSION;
              take_version(c);
            end else begin
              bad = 1'b1;
            end
          end
          wac_pkg::PH_VERSION: take_version(c);
          wac_pkg::PH_TYPE: begin
            phase = wac_pkg::PH_ROW;
            if (c == wac_pkg::CH_S_LO || c == wac_pkg::CH_S_UP) begin
              kind = wac_pkg::KIND_SCAFFOLD;
            end else if (c == wac_pkg::CH_P_LO || c == wac_pkg::CH_P_UP) begin
              kind = wac_pkg::KIND_PROTEIN;
            end else begin
              kind = wac_pkg::KIND_CONTIG;
              take_row(c);
            end
          end
          default: take_row(c);
        endcase
      end
      if (last) begin
        six = (letters == wac_pkg::LETTERS_SIX);
        rmin = six ? wac_pkg::ROW_MIN_SIX : wac_pkg::ROW_MIN_FOUR;
        rmax = six ? wac_pkg::ROW_MAX_SIX : wac_pkg::ROW_MAX_FOUR;
        ok = !bad && phase == wac_pkg::PH_ROW
          && pos >= wac_pkg::LEN_MIN && pos <= wac_pkg::LEN_MAX
          && kinds_mask[kind] && row_cnt >= rmin && row_cnt <= rmax && row_nz;
        v.acc = ok;
        v.kind = ok ? kind : wac_pkg::KIND_CONTIG;
        v.six = ok && six;
        verdict_q.push_back(v);
        clear();
      end
    endfunction

    task report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_verdict(input logic acc, input logic [1:0] kind_o, input logic six_o);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        report("verdict beat with no verdict pending");
        return;
      end
      want = verdict_q.pop_front();
      if (acc !== want.acc)
        report($sformatf("accepted got %b expected %b", acc, want.acc));
      if (kind_o !== want.kind)
        report($sformatf("seq_kind got %0d expected %0d", kind_o, want.kind));
      if (six_o !== want.six)
        report($sformatf("six_letter_form got %b expected %b", six_o, want.six));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] char_code;
  logic       last_char;
  logic       out_valid;
  logic       out_ready;
  logic       accepted;
  logic [1:0] seq_kind;
  logic       six_letter_form;
  logic       cfg_wr_en;
  logic [2:0] cfg_wr_data;

  accession_scoreboard sb;
  logic [7:0] chars_q[$];
  int         idle_pct;
  int         stall_pct;
  int         sent;
  bit         hold_req;

  wgs_accession_checker dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .char_code       (char_code),
    .last_char       (last_char),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .accepted        (accepted),
    .seq_kind        (seq_kind),
    .six_letter_form (six_letter_form),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  always #4 clk = ~clk;

  task automatic send_char(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    char_code <= c;
    last_char <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_char(c, last);
    sent++;
  endtask

  task automatic send_word();
    int i;
    for (i = 0; i < chars_q.size(); i++)
      send_char(chars_q[i], i == chars_q.size() - 1);
  endtask

  task automatic send_text(input string s);
    int i;
    chars_q.delete();
    for (i = 0; i < s.len(); i++) chars_q.push_back(s[i]);
    send_word();
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mask(input logic [2:0] m);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.kinds_mask = m;
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] base;
    base = $urandom_range(1) ? wac_pkg::CH_A_UP : wac_pkg::CH_A_LO;
    return base + 8'($urandom_range(25));
  endfunction

  // mostly well-formed accessions, some broken, some raw noise
  task automatic gen_word();
    int mode;
    int n;
    int row_len;
    int cut;
    bit six;
    bit zero_row;
    mode = $urandom_range(99);
    chars_q.delete();
    if (mode < 12) begin
      n = $urandom_range(1, 24);
      repeat (n) chars_q.push_back(8'($urandom_range(255)));
      return;
    end
    six = ($urandom_range(1) != 0);
    n = six ? 6 : 4;
    if ($urandom_range(19) == 0) n = $urandom_range(1, 5);
    repeat (n) chars_q.push_back(rand_letter());
    repeat (2) chars_q.push_back(wac_pkg::CH_ZERO + 8'($urandom_range(9)));
    case ($urandom_range(4))
      1: chars_q.push_back(wac_pkg::CH_S_LO);
      2: chars_q.push_back(wac_pkg::CH_S_UP);
      3: chars_q.push_back(wac_pkg::CH_P_LO);
      4: chars_q.push_back(wac_pkg::CH_P_UP);
      default: ;
    endcase
    row_len = six ? $urandom_range(6, 10) : $urandom_range(5, 8);
    zero_row = ($urandom_range(9) == 0);
    repeat (row_len)
      chars_q.push_back(zero_row ? wac_pkg::CH_ZERO
                                 : wac_pkg::CH_ZERO + 8'($urandom_range(9)));
    if (mode >= 75) begin
      case ($urandom_range(3))
        0: chars_q[$urandom_range(chars_q.size() - 1)] = 8'($urandom_range(255));
        1: begin
          cut = $urandom_range(1, chars_q.size() - 1);
          while (chars_q.size() > cut) void'(chars_q.pop_back());
        end
        2: repeat ($urandom_range(1, 30))
             chars_q.push_back(wac_pkg::CH_ZERO + 8'($urandom_range(9)));
        default: chars_q.insert($urandom_range(chars_q.size() - 1), rand_letter());
      endcase
    end
  endtask

  // result side: checks every verdict beat, stalls at random or for a long hold
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        sb.check_verdict(accepted, seq_kind, six_letter_form);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
        if (hold_left == 0) hold_req = 1'b0;
      end else if (hold_req) begin
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int seg;
    int target;
    sb = new();
    sent = 0;
    hold_req = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    char_code <= '0;
    last_char <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed strings under the reset mask
    send_text("ABCD12123456");
    send_text("azbzcd34s1234567");
    send_text("WXYZZZ56P123456789");
    send_text("QRST00000000");
    send_text("ABCDE1234567890");
    send_text("AB");
    send_char(8'hff, 1'b1);
    send_char(8'h00, 1'b1);

    for (seg = 0; seg < 8; seg++) begin
      write_mask(MASK_PLAN[seg]);
      case (seg % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 49; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      target = sent + SEG_ITEMS;
      while (sent < target) begin
        gen_word();
        send_word();
      end
      if (seg == 0) begin
        // receiver holds off while strings keep coming, so the input stalls
        hold_req = 1'b1;
        while (hold_req) begin
          gen_word();
          send_word();
        end
      end
    end

    wait_idle();
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
